// ===== src/dorq_pkg.sv =====
// Package for the decimating overwrite ring queue.
// Holds opcodes, register indexes, reset values, the controller state type
// and the command struct; no dependencies.
`default_nettype none

package dorq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PHASE_W  = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DECIM_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_DEN  = 1'd1;

  localparam logic [CFG_W-1:0] DECIM_STEP_RST = 4'd2;
  localparam logic [CFG_W-1:0] DECIM_DEN_RST  = 4'd3;

  typedef enum logic {
    ST_IDLE,
    ST_DELIVER
  } ctrl_state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic load;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/dorq_in_if.sv =====
// Request channel interface: valid/ready handshake with opcode and sample.
// Depends on dorq_pkg for field widths.
`default_nettype none

interface dorq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [dorq_pkg::SAMPLE_W-1:0] in_sample;
  logic                                burst_last;

  modport source (output valid, output opcode, output in_sample, output burst_last,
                  input ready);
  modport sink   (input valid, input opcode, input in_sample, input burst_last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/dorq_out_if.sv =====
// Result channel interface: valid/ready handshake with popped sample and flags.
// Depends on dorq_pkg for field widths.
`default_nettype none

interface dorq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dorq_pkg::SAMPLE_W-1:0] out_sample;
  logic                                from_queue;
  logic                                frame_last;

  modport source (output valid, output out_sample, output from_queue, output frame_last,
                  input ready);
  modport sink   (input valid, input out_sample, input from_queue, input frame_last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/decimating_overwrite_ring_queue_top.sv =====
// Top level of the decimating overwrite ring queue.
// Depends on dorq_pkg, dorq_in_if, dorq_out_if, dorq_ctrl and dorq_dp.
// Usage:
//   in_ch carries requests: opcode push (store in_sample when the phase
//   accumulator wraps) or pop (return the oldest sample). Pushes give no
//   result; every pop gives exactly one transaction on out_ch, with zero and
//   from_queue low when the queue is empty, and frame_last copied from the
//   request's burst_last. A store into a full queue drops the oldest entry.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write decim_step (index 0) and decim_den
//   (index 1); write only while the block is idle.
// Timing:
//   A push is taken while idle; in_ch.ready stays high across pushes.
//   A pop reads the single-port sample memory at the accept edge and moves
//   the controller to deliver; the result register is loaded from there once
//   out_ch is free (valid low or ready high), and out_ch.valid is registered
//   with it. in_ch.ready is low in deliver, so pops do not overlap.
//   While out_ch is stalled, pushes are still taken; a following pop is
//   taken, then in_ch.ready stays low until the held result is taken.
// Reset: counters, phase and valid clear; step/den return to 2 and 3.
`default_nettype none

module decimating_overwrite_ring_queue_top #(
  parameter int unsigned QUEUE_DEPTH = dorq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  dorq_in_if.sink                             in_ch,
  dorq_out_if.source                          out_ch,
  input  wire logic                           cfg_we_i,
  input  wire logic [dorq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dorq_pkg::CFG_W-1:0]     cfg_wdata_i
);

  dorq_pkg::dp_cmd_t cmd;

  dorq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_opcode_i (in_ch.opcode),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd)
  );

  dorq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_sample_i  (in_ch.in_sample),
    .burst_last_i (in_ch.burst_last),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_sample_o (out_ch.out_sample),
    .from_queue_o (out_ch.from_queue),
    .frame_last_o (out_ch.frame_last)
  );

endmodule

`default_nettype wire

// ===== src/dorq_ctrl.sv =====
// Controller for the decimating overwrite ring queue: handshake and sequencing.
// Depends on dorq_pkg; drives dp_cmd_t commands into dorq_dp.
`default_nettype none

module dorq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_opcode_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output dorq_pkg::dp_cmd_t      cmd_o
);

  dorq_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dorq_pkg::ST_IDLE: begin
        if (in_valid_i && (in_opcode_i == dorq_pkg::OP_POP)) begin
          state_d = dorq_pkg::ST_DELIVER;
        end
      end
      dorq_pkg::ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = dorq_pkg::ST_IDLE;
        end
      end
      default: state_d = dorq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      dorq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.push = in_valid_i && (in_opcode_i == dorq_pkg::OP_PUSH);
        cmd_o.pop  = in_valid_i && (in_opcode_i == dorq_pkg::OP_POP);
      end
      dorq_pkg::ST_DELIVER: begin
        cmd_o.load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dorq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_pop_enters_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (state_q == dorq_pkg::ST_DELIVER))
    else $error("pop did not move to deliver");

  a_deliver_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dorq_pkg::ST_DELIVER) && !cmd_o.load |=> (state_q == dorq_pkg::ST_DELIVER))
    else $error("pending pop result dropped");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== src/dorq_dp.sv =====
// Datapath for the decimating overwrite ring queue: config registers, phase
// accumulator, ring counters, sample memory and result register. Uses dorq_pkg.
`default_nettype none

module dorq_dp #(
  parameter int unsigned QUEUE_DEPTH = dorq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire dorq_pkg::dp_cmd_t                    cmd_i,
  input  wire logic signed [dorq_pkg::SAMPLE_W-1:0] in_sample_i,
  input  wire logic                                 burst_last_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dorq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [dorq_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic signed [dorq_pkg::SAMPLE_W-1:0]      out_sample_o,
  output logic                                      from_queue_o,
  output logic                                      frame_last_o
);

  localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(2 * QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(2 * QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   SPAN      = (CNT_W + 1)'(2 * QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_OCC = (CNT_W + 1)'(QUEUE_DEPTH);

  logic [dorq_pkg::CFG_W-1:0]   step_q, den_q;
  logic [dorq_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]             wr_cnt_q, wr_cnt_d, rd_cnt_q, rd_cnt_d;

  logic [dorq_pkg::SAMPLE_W-1:0] mem [QUEUE_DEPTH];
  logic [dorq_pkg::SAMPLE_W-1:0] rdata_q;
  logic                          hit_q;
  logic                          last_q;

  logic signed [dorq_pkg::SAMPLE_W-1:0] out_sample_q;
  logic                                 from_queue_q;
  logic                                 frame_last_q;

  logic [dorq_pkg::CFG_W-1:0]   step_eff;
  logic [dorq_pkg::PHASE_W:0]   phase_sum_w;
  logic [dorq_pkg::PHASE_W-1:0] phase_sum;
  logic                         store;
  logic [CNT_W:0]               occ;
  logic                         full, empty;
  logic [CNT_W-1:0]             wr_inc, rd_inc;
  logic [ADDR_W-1:0]            wr_slot, rd_slot;
  logic                         mem_we, mem_re;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c == CNT_MAX) ? '0 : c + CNT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] s;
    s = (c >= DEPTH_CNT) ? c - DEPTH_CNT : c;
    slot_of = s[ADDR_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dorq_pkg::DECIM_STEP_RST;
      den_q  <= dorq_pkg::DECIM_DEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dorq_pkg::REG_DECIM_STEP) begin
        step_q <= cfg_wdata_i;
      end else if (cfg_idx_i == dorq_pkg::REG_DECIM_DEN) begin
        den_q <= cfg_wdata_i;
      end
    end
  end

  assign step_eff    = (step_q > den_q) ? den_q : step_q;
  assign phase_sum_w = {1'b0, phase_q} + (dorq_pkg::PHASE_W + 1)'(step_eff);
  assign phase_sum   = phase_sum_w[dorq_pkg::PHASE_W-1:0];
  assign store       = cmd_i.push && (phase_sum >= dorq_pkg::PHASE_W'(den_q));

  assign occ   = (wr_cnt_q >= rd_cnt_q) ? {1'b0, wr_cnt_q} - {1'b0, rd_cnt_q}
                                        : {1'b0, wr_cnt_q} + SPAN - {1'b0, rd_cnt_q};
  assign full  = occ >= DEPTH_OCC;
  assign empty = (wr_cnt_q == rd_cnt_q);

  assign wr_inc  = cnt_inc(wr_cnt_q);
  assign rd_inc  = cnt_inc(rd_cnt_q);
  assign wr_slot = slot_of(wr_cnt_q);
  assign rd_slot = slot_of(rd_cnt_q);
  assign mem_we  = store;
  assign mem_re  = cmd_i.pop && !empty;

  always_comb begin
    phase_d  = phase_q;
    wr_cnt_d = wr_cnt_q;
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.push) begin
      phase_d = store ? phase_sum - dorq_pkg::PHASE_W'(den_q) : phase_sum;
    end
    if (store) begin
      wr_cnt_d = wr_inc;
      if (full) begin
        rd_cnt_d = rd_inc;
      end
    end
    if (mem_re) begin
      rd_cnt_d = rd_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      wr_cnt_q <= '0;
      rd_cnt_q <= '0;
    end else begin
      phase_q  <= phase_d;
      wr_cnt_q <= wr_cnt_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_slot] <= in_sample_i;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      hit_q  <= !empty;
      last_q <= burst_last_i;
    end
    if (cmd_i.load) begin
      out_sample_q <= hit_q ? $signed(rdata_q) : '0;
      from_queue_q <= hit_q;
      frame_last_q <= last_q;
    end
  end

  assign out_sample_o = out_sample_q;
  assign from_queue_o = from_queue_q;
  assign frame_last_o = frame_last_q;

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= DEPTH_OCC)
    else $error("occupancy above depth");

  a_overwrite_keeps_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store && full |=> occ == DEPTH_OCC)
    else $error("overwrite changed occupancy");

  a_pop_drains_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> occ == $past(occ) - (CNT_W + 1)'(1))
    else $error("pop did not remove one entry");

  a_phase_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= dorq_pkg::PHASE_W'(29))
    else $error("phase out of range");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for decimating_overwrite_ring_queue_top: directed table, then random phases
// under several decimation settings, each pop checked against a local queue model or the
// table (check rows). Depends on dorq_pkg, dorq_in_if, dorq_out_if and the block's RTL.

module tb;

  localparam int unsigned DEPTH      = dorq_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned SPAN       = 2 * DEPTH;
  localparam int          IDLE_PCT   = 30;
  localparam int          DRAIN_GAP  = 4;
  localparam int          STALL_MAX  = 2000;
  localparam int          RAND_PHASES = 12;
  localparam int          PHASE_ITEMS = 115;

  typedef struct packed {
    logic [dorq_pkg::SAMPLE_W-1:0] smp;
    logic                          fq;
    logic                          last;
  } pop_rec_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_REQ,
    ROW_CHK
  } row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [dorq_pkg::CFG_IDX_W-1:0] idx;
    logic [dorq_pkg::CFG_W-1:0]     wdata;
    logic                           op;
    logic [dorq_pkg::SAMPLE_W-1:0]  smp;
    logic                           last;
    logic [dorq_pkg::SAMPLE_W-1:0]  e_smp;
    logic                           e_fq;
  } row_t;

  localparam int N_ROWS = 35;
  localparam row_t DIR_TAB [N_ROWS] = '{
    '{ROW_CHK, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h8000, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h1234, 1'b1, 16'h0000, 1'b0},
    '{ROW_CHK, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b0, 16'h7FFF, 1'b1},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'hA5A5, 1'b1, 16'h0000, 1'b0},
    '{ROW_CHK, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h5A5A, 1'b0, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_STEP, 4'd1,  dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_DEN,  4'd1,  dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h8000, 1'b1, 16'h0000, 1'b0},
    '{ROW_CHK, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_CHK, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'hFFFF, 1'b0, 16'h8000, 1'b1},
    '{ROW_CFG, dorq_pkg::REG_DECIM_STEP, 4'd15, dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_DEN,  4'd15, dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h0001, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_DEN,  4'd0,  dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h5555, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'hAAAA, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_DEN,  4'd15, dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h0F0F, 1'b1, 16'h0000, 1'b0},
    '{ROW_CHK, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_STEP, 4'd14, dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'hF0F0, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'h3C3C, 1'b1, 16'h0000, 1'b0},
    '{ROW_CFG, dorq_pkg::REG_DECIM_DEN,  4'd2,  dorq_pkg::OP_PUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_PUSH, 16'hC3C3, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ, dorq_pkg::REG_DECIM_STEP, 4'd0,  dorq_pkg::OP_POP,  16'hFFFF, 1'b0, 16'h0000, 1'b0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dorq_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dorq_pkg::CFG_W-1:0]     cfg_wdata_i;

  dorq_in_if  in_ch();
  dorq_out_if out_ch();

  decimating_overwrite_ring_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  logic [dorq_pkg::SAMPLE_W-1:0] mdl_store [DEPTH];
  int unsigned                   mdl_wr;
  int unsigned                   mdl_rd;
  logic [dorq_pkg::PHASE_W-1:0]  mdl_phase;
  logic [dorq_pkg::CFG_W-1:0]    mdl_step;
  logic [dorq_pkg::CFG_W-1:0]    mdl_den;

  pop_rec_t pop_results_due[$];
  int       err_cnt;
  bit       calm;
  int       stall_cycles;

  task automatic queue_model_apply(input logic op, input logic [dorq_pkg::SAMPLE_W-1:0] smp,
                                   input logic last, output bit gives, output pop_rec_t rec);
    logic [dorq_pkg::CFG_W-1:0] eff_step;
    int unsigned                fill;
    fill  = (mdl_wr + SPAN - mdl_rd) % SPAN;
    gives = 1'b0;
    rec   = '0;
    if (op == dorq_pkg::OP_PUSH) begin
      eff_step  = (mdl_step > mdl_den) ? mdl_den : mdl_step;
      mdl_phase = mdl_phase + dorq_pkg::PHASE_W'(eff_step);
      if (mdl_phase >= dorq_pkg::PHASE_W'(mdl_den)) begin
        mdl_phase = mdl_phase - dorq_pkg::PHASE_W'(mdl_den);
        // drop the oldest entry on a full queue
        if (fill >= DEPTH) mdl_rd = (mdl_rd + 1) % SPAN;
        mdl_store[ADDR_W'(mdl_wr % DEPTH)] = smp;
        mdl_wr = (mdl_wr + 1) % SPAN;
      end
    end else begin
      gives    = 1'b1;
      rec.last = last;
      if (fill > 0) begin
        rec.smp = mdl_store[ADDR_W'(mdl_rd % DEPTH)];
        rec.fq  = 1'b1;
        mdl_rd  = (mdl_rd + 1) % SPAN;
      end
    end
  endtask

  task automatic send_request(input logic op, input logic [dorq_pkg::SAMPLE_W-1:0] smp,
                              input logic last, input bit typed,
                              input logic [dorq_pkg::SAMPLE_W-1:0] t_smp,
                              input logic t_fq);
    bit       gives;
    pop_rec_t rec;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.in_sample  <= smp;
    in_ch.burst_last <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    queue_model_apply(op, smp, last, gives, rec);
    if (gives) begin
      if (typed) begin
        rec.smp = t_smp;
        rec.fq  = t_fq;
      end
      pop_results_due.push_back(rec);
    end
  endtask

  task automatic write_reg(input logic [dorq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dorq_pkg::CFG_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pop_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dorq_pkg::REG_DECIM_STEP) mdl_step = val;
    else mdl_den = val;
  endtask

  always @(posedge clk_i) begin
    pop_rec_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pop_results_due.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result: exp none got %h/%b/%b", $time, out_ch.out_sample,
                 out_ch.from_queue, out_ch.frame_last);
      end else begin
        want = pop_results_due.pop_front();
        if (out_ch.out_sample !== want.smp) begin
          err_cnt++;
          $display("%0t out_sample: exp %h got %h", $time, want.smp, out_ch.out_sample);
        end
        if (out_ch.from_queue !== want.fq) begin
          err_cnt++;
          $display("%0t from_queue: exp %b got %b", $time, want.fq, out_ch.from_queue);
        end
        if (out_ch.frame_last !== want.last) begin
          err_cnt++;
          $display("%0t frame_last: exp %b got %b", $time, want.last, out_ch.frame_last);
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [dorq_pkg::CFG_W-1:0] s_val;
    logic [dorq_pkg::CFG_W-1:0] d_val;
    int                         push_pct;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = dorq_pkg::OP_PUSH;
    in_ch.in_sample  = '0;
    in_ch.burst_last = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = dorq_pkg::REG_DECIM_STEP;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    err_cnt          = 0;
    stall_cycles     = 0;
    calm             = 1'b0;
    mdl_wr           = 0;
    mdl_rd           = 0;
    mdl_phase        = '0;
    mdl_step         = dorq_pkg::DECIM_STEP_RST;
    mdl_den          = dorq_pkg::DECIM_DEN_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) write_reg(DIR_TAB[i].idx, DIR_TAB[i].wdata);
      else send_request(DIR_TAB[i].op, DIR_TAB[i].smp, DIR_TAB[i].last,
                        DIR_TAB[i].kind == ROW_CHK, DIR_TAB[i].e_smp, DIR_TAB[i].e_fq);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          s_val = 4'd15;
          d_val = 4'd15;
        end
        1: begin
          s_val = 4'd1;
          d_val = 4'd1;
        end
        2: begin
          s_val = 4'd0;
          d_val = 4'd0;
        end
        3: begin
          s_val = 4'd15;
          d_val = 4'd1;
        end
        4: begin
          s_val = dorq_pkg::DECIM_STEP_RST;
          d_val = dorq_pkg::DECIM_DEN_RST;
        end
        default: begin
          s_val = dorq_pkg::CFG_W'($urandom_range(0, 15));
          d_val = dorq_pkg::CFG_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(dorq_pkg::REG_DECIM_STEP, s_val);
      write_reg(dorq_pkg::REG_DECIM_DEN, d_val);
      calm     = (ph == 5) || (ph == 6);
      push_pct = (ph % 3 == 0) ? 80 : int'($urandom_range(25, 75));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(($urandom_range(0, 99) < push_pct) ? dorq_pkg::OP_PUSH : dorq_pkg::OP_POP,
                     dorq_pkg::SAMPLE_W'($urandom), 1'($urandom), 1'b0, '0, 1'b0);
      end
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (pop_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
